// File: hdl/slsw_pkg.sv
// Shared types and constants for the signal-loss safety watchdog.
// Item structs, configuration struct, command/result codes, register map.
// No dependencies.
`default_nettype none

package slsw_pkg;

    // Input item as carried on the input channel
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [7:0]  quality;
    } t_in_item;

    // Result item as carried on the output channel
    typedef struct packed {
        logic        is_safe;
        logic [1:0]  move_request;
        logic [1:0]  drive_change;
        logic [31:0] last_valid_ms;
    } t_out_item;

    // Configuration as seen by the core
    typedef struct packed {
        logic        monitor_enable;
        logic [15:0] loss_timeout_ms;
        logic [15:0] poor_timeout_ms;
    } t_cfg;

    // Command codes
    localparam logic [1:0] CMD_CHECK   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [1:0] CMD_STOP    = 2'd2;
    localparam logic [1:0] CMD_RELEASE = 2'd3;

    // Safe-pose move requests
    localparam logic [1:0] MOVE_NONE = 2'd0;
    localparam logic [1:0] MOVE_SLOW = 2'd1;
    localparam logic [1:0] MOVE_FAST = 2'd2;

    // Drive enable changes
    localparam logic [1:0] DRIVE_KEEP = 2'd0;
    localparam logic [1:0] DRIVE_ON   = 2'd1;
    localparam logic [1:0] DRIVE_OFF  = 2'd2;

    // Quality above this level counts as bad
    localparam logic [7:0] QUALITY_BAD_ABOVE = 8'd200;

    // Register reset values
    localparam logic [15:0] LOSS_TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] POOR_TIMEOUT_RESET = 16'd10000;

    // Register map: word index = paddr[3:2]
    localparam int          ADDR_W       = 4;
    localparam logic [1:0]  REG_MON_EN   = 2'd0;
    localparam logic [1:0]  REG_LOSS_TO  = 2'd1;
    localparam logic [1:0]  REG_POOR_TO  = 2'd2;

endpackage

`default_nettype wire

// File: hdl/signal_loss_safety_watchdog.sv
// Top level of the signal-loss safety watchdog for a servo drive.
// Input register, decision core, result register, APB registers.
// Depends on slsw_pkg, slsw_regs, slsw_core.
//
//  channel | signals                               | moves
//  --------+---------------------------------------+---------------------------
//  input   | i_in_valid / o_in_ready / i_in_item    | one command item
//  output  | o_out_valid / i_out_ready / o_out_item | one result item per input
//  config  | psel penable pwrite paddr pwdata ...   | register write / read
//
// An accepted item waits in the input register until the result register can
// take its result. One item per cycle sustained while the output is not
// stalled, set by the combinational decision path between the two registers.
// Reset (synchronous, active low) clears the state and valid flags and loads the register reset values.
// A stalled result holds in the output register; the input register takes a
// new item when it is empty or its content moves forward in the same cycle.
`default_nettype none

module signal_loss_safety_watchdog (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire slsw_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output slsw_pkg::t_out_item              o_out_item,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [slsw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    slsw_pkg::t_cfg      cfg;
    slsw_pkg::t_in_item  r_in;
    logic                r_in_valid;
    slsw_pkg::t_out_item r_out;
    logic                r_out_valid;
    slsw_pkg::t_out_item result;
    logic                step;

    slsw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // item leaves the input register when the result register is free
    assign step       = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | step;

    slsw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: hdl/slsw_regs.sv
// APB-style configuration registers of the signal-loss watchdog.
// Holds monitor enable and the two timeouts; depends on slsw_pkg.
`default_nettype none

module slsw_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [slsw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output slsw_pkg::t_cfg                   o_cfg
);

    logic        r_mon_en;
    logic [15:0] r_loss_to;
    logic [15:0] r_poor_to;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;

    // register writes; an index past the map is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mon_en  <= 1'b0;
            r_loss_to <= slsw_pkg::LOSS_TIMEOUT_RESET;
            r_poor_to <= slsw_pkg::POOR_TIMEOUT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                slsw_pkg::REG_MON_EN:  r_mon_en  <= pwdata[0];
                slsw_pkg::REG_LOSS_TO: r_loss_to <= pwdata[15:0];
                slsw_pkg::REG_POOR_TO: r_poor_to <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            slsw_pkg::REG_MON_EN:  prdata = {31'd0, r_mon_en};
            slsw_pkg::REG_LOSS_TO: prdata = {16'd0, r_loss_to};
            slsw_pkg::REG_POOR_TO: prdata = {16'd0, r_poor_to};
            default:               prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{monitor_enable:  r_mon_en,
                     loss_timeout_ms: r_loss_to,
                     poor_timeout_ms: r_poor_to};

endmodule

`default_nettype wire

// File: hdl/slsw_core.sv
// Watchdog state and per-item decision logic.
// Holds last valid time, bad-run start and emergency flag; depends on slsw_pkg.
`default_nettype none

module slsw_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire slsw_pkg::t_cfg     i_cfg,
    input  wire logic               i_step,
    input  wire slsw_pkg::t_in_item i_item,
    output slsw_pkg::t_out_item     o_result
);

    logic [31:0] r_last_valid;
    logic [31:0] r_bad_start;
    logic        r_emerg;
    logic [31:0] n_last_valid;
    logic [31:0] n_bad_start;
    logic        n_emerg;
    logic [1:0]  move;
    logic [1:0]  drive;
    logic [31:0] loss_age;
    logic [31:0] bad_age;
    logic        loss_trip;
    logic        bad_trip;

    // wrapping ages against zero-extended timeouts
    assign loss_age  = i_item.now_ms - r_last_valid;
    assign bad_age   = i_item.now_ms - r_bad_start;
    assign loss_trip = (loss_age > {16'd0, i_cfg.loss_timeout_ms});
    assign bad_trip  = (bad_age > {16'd0, i_cfg.poor_timeout_ms});

    // next state and result codes for the item at the core
    always_comb begin
        n_last_valid = r_last_valid;
        n_bad_start  = r_bad_start;
        n_emerg      = r_emerg;
        move         = slsw_pkg::MOVE_NONE;
        drive        = slsw_pkg::DRIVE_KEEP;
        unique case (i_item.cmd)
            slsw_pkg::CMD_CHECK: begin
                if (i_cfg.monitor_enable && !r_emerg && (r_last_valid != 32'd0) &&
                    loss_trip) begin
                    move    = slsw_pkg::MOVE_SLOW;
                    drive   = slsw_pkg::DRIVE_OFF;
                    n_emerg = 1'b1;
                end
            end
            slsw_pkg::CMD_SAMPLE: begin
                if (i_cfg.monitor_enable) begin
                    priority if (i_item.quality == 8'd0) begin
                        n_last_valid = i_item.now_ms;
                        n_bad_start  = 32'd0;
                        if (r_emerg) begin
                            n_emerg = 1'b0;
                            drive   = slsw_pkg::DRIVE_ON;
                        end
                    end else if (i_item.quality > slsw_pkg::QUALITY_BAD_ABOVE) begin
                        // bad run: start it, or trip once it has lasted too long
                        if (r_bad_start == 32'd0) begin
                            n_bad_start = i_item.now_ms;
                        end else if (bad_trip && !r_emerg) begin
                            move    = slsw_pkg::MOVE_SLOW;
                            n_emerg = 1'b1;
                        end
                    end else begin
                        n_bad_start  = 32'd0;
                        n_last_valid = i_item.now_ms;
                    end
                end
            end
            slsw_pkg::CMD_STOP: begin
                n_emerg = 1'b1;
                move    = slsw_pkg::MOVE_FAST;
                drive   = slsw_pkg::DRIVE_OFF;
            end
            slsw_pkg::CMD_RELEASE: begin
                n_emerg      = 1'b0;
                n_last_valid = i_item.now_ms;
                drive        = slsw_pkg::DRIVE_ON;
            end
            default: ;
        endcase
    end

    // state advances only when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 32'd0;
            r_bad_start  <= 32'd0;
            r_emerg      <= 1'b0;
        end else if (i_step) begin
            r_last_valid <= n_last_valid;
            r_bad_start  <= n_bad_start;
            r_emerg      <= n_emerg;
        end
    end

    assign o_result = '{is_safe:       !n_emerg,
                        move_request:  move,
                        drive_change:  drive,
                        last_valid_ms: n_last_valid};

endmodule

`default_nettype wire

// File: hdl/slsw_checker.sv
// Port-level checks for the signal-loss safety watchdog.
// Bound to signal_loss_safety_watchdog; depends on slsw_pkg.
`default_nettype none

module slsw_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire slsw_pkg::t_out_item o_out_item,
    input wire logic                pready
);

    // a pending result is never withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stop disables the drive and leaves the block unsafe
    a_stop_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.move_request == slsw_pkg::MOVE_FAST) |->
            (o_out_item.drive_change == slsw_pkg::DRIVE_OFF) && !o_out_item.is_safe)
        else $error("fast move without drive off");

    // any trip reports unsafe; a drive enable reports safe with no move request
    a_trip_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.move_request != slsw_pkg::MOVE_NONE) |->
            !o_out_item.is_safe)
        else $error("move request while safe");

    a_enable_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.drive_change == slsw_pkg::DRIVE_ON) |->
            o_out_item.is_safe && (o_out_item.move_request == slsw_pkg::MOVE_NONE)
            && pready)
        else $error("drive enable while unsafe");

endmodule

bind signal_loss_safety_watchdog slsw_checker u_slsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .pready      (pready)
);

`default_nettype wire
